### sv/srd_pkg.sv
// shared constants for the stick radial deadzone block
package srd_pkg;

  // field widths
  localparam int RAW_W = 16;
  localparam int OUT_W = 17;
  localparam int DZ_W  = 15;

  // deadzone register reset value, about 0.15 of full scale
  localparam logic [DZ_W-1:0] DZ_RESET = 15'd4915;

  // positive full scale of a raw sample, the divisor for positive values
  localparam int RAW_POS_FS = 32767;

  // largest output magnitude
  localparam logic [OUT_W-1:0] OUT_MAX = 17'd32768;

  // depth of the queues between the parts
  localparam int QUEUE_DEPTH = 4;

endpackage

### sv/srd_fifo.sv
// small register queue with full and empty flags
module srd_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

### sv/srd_front.sv
// front part: normalizes a sample, squares the axes and classifies against the deadzone
module srd_front #(
  parameter int FRAC_BITS = 15
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_push,
  output logic                                  in_full,
  input  logic signed [srd_pkg::RAW_W-1:0]      in_raw_x,
  input  logic signed [srd_pkg::RAW_W-1:0]      in_raw_y,
  input  logic [FRAC_BITS-1:0]                  dz,
  input  logic                                  mid_full,
  output logic                                  mid_push,
  output logic [4*FRAC_BITS+7-1:0]              mid_data
);
  import srd_pkg::*;

  localparam int F  = FRAC_BITS;
  localparam int AW = F + 1;
  localparam int SW = 2 * F + 2;
  localparam int NW = 15 + F;

  // magnitude in fixed point with the sign on top
  function automatic logic [AW:0] norm_mag(input logic [RAW_W-1:0] raw);
    logic [16:0]   absv;
    logic [16+F:0] nn;
    logic [NW-1:0] n;
    logic [NW:0]   acc;
    logic [AW-1:0] est;
    logic [NW:0]   prod;
    logic [NW:0]   rem;
    logic [AW-1:0] mag;
    absv = 17'h10000 - {1'b0, raw};
    nn   = {absv, {F{1'b0}}};
    n    = {raw[14:0], {F{1'b0}}};
    // reciprocal of 32767 as n*(1+2^-15), then correct by the remainder
    acc  = {1'b0, n} + (NW+1)'(n >> 15);
    est  = AW'(acc >> 15);
    prod = {est, 15'b0} - (NW+1)'(est);
    rem  = {1'b0, n} - prod;
    if (raw[RAW_W-1]) begin
      mag = AW'(nn >> 15);
    end else if (rem >= (NW+1)'(2 * RAW_POS_FS)) begin
      mag = est + AW'(2);
    end else if (rem >= (NW+1)'(RAW_POS_FS)) begin
      mag = est + AW'(1);
    end else begin
      mag = est;
    end
    return {raw[RAW_W-1], mag};
  endfunction

  logic          adv;
  logic [AW:0]   nmx, nmy;
  logic          va_r, vb_r;
  logic [AW-1:0] ax_r, ay_r, bax_r, bay_r;
  logic          nx_r, ny_r, bnx_r, bny_r;
  logic [SW-1:0] sx_r, sy_r;
  logic [2*F-1:0] dz_sq_r;
  logic [SW-1:0] sum;
  logic          in_dz;

  // both stages move together unless the second stage holds a beat and the queue is full
  assign adv     = !vb_r || !mid_full;
  assign in_full = !adv;
  assign nmx     = norm_mag(in_raw_x);
  assign nmy     = norm_mag(in_raw_y);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else if (adv) begin
      va_r <= in_push;
      vb_r <= va_r;
    end
  end

  // normalize, then square
  always_ff @(posedge clk) begin
    dz_sq_r <= (2*F)'(dz) * (2*F)'(dz);
    if (adv) begin
      ax_r  <= nmx[AW-1:0];
      ay_r  <= nmy[AW-1:0];
      nx_r  <= nmx[AW];
      ny_r  <= !nmy[AW];
      sx_r  <= SW'(ax_r) * SW'(ax_r);
      sy_r  <= SW'(ay_r) * SW'(ay_r);
      bax_r <= ax_r;
      bay_r <= ay_r;
      bnx_r <= nx_r;
      bny_r <= ny_r;
    end
  end

  // deadzone test on the squared length
  assign sum      = sx_r + sy_r;
  assign in_dz    = (sum <= SW'(dz_sq_r));
  assign mid_push = vb_r && !mid_full;
  assign mid_data = {bax_r, bay_r, sum, bnx_r, bny_r, in_dz};

endmodule

### sv/srd_back.sv
// back part: pipelined square root, scale products and pipelined divider
module srd_back #(
  parameter int FRAC_BITS = 15
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic [FRAC_BITS-1:0]                  dz,
  input  logic                                  mid_empty,
  output logic                                  mid_pop,
  input  logic [4*FRAC_BITS+7-1:0]              mid_data,
  input  logic                                  out_full,
  output logic                                  out_push,
  output logic [2*srd_pkg::OUT_W:0]             out_data
);
  import srd_pkg::*;

  localparam int F   = FRAC_BITS;
  localparam int AW  = F + 1;
  localparam int LW  = F + 1;
  localparam int QW  = F + 1;
  localparam int SW  = 2 * F + 2;
  localparam int MW  = 4 * F + 7;
  localparam int NSQ = F + 2;
  localparam int NDV = F + 1;
  localparam logic [LW-1:0] ONE = {1'b1, {F{1'b0}}};

  // quotient to output units with saturation and sign
  function automatic logic [OUT_W-1:0] to_field(input logic [QW-1:0] q, input logic neg);
    logic [F+15:0]    wide;
    logic [OUT_W-1:0] m;
    wide = {q, 15'b0};
    m    = OUT_W'(wide >> F);
    if (m > OUT_MAX) begin
      m = OUT_MAX;
    end
    return neg ? (OUT_W'(0) - m) : m;
  endfunction

  logic adv;

  // square root stages
  logic [NSQ-1:0] sv_r;
  logic [SW-1:0]  srem_r  [NSQ];
  logic [SW-1:0]  sroot_r [NSQ];
  logic [AW-1:0]  sax_r   [NSQ];
  logic [AW-1:0]  say_r   [NSQ];
  logic [NSQ-1:0] snx_r, sny_r, sin_r;

  // product stage
  logic          mv_r, mnx_r, mny_r, min_r;
  logic [SW-1:0] mpx_r, mpy_r, mden_r;
  logic [LW-1:0] len, mlim, tnum, omd;

  // divider stages
  logic [NDV-1:0] dv_r, dnx_r, dny_r, din_r;
  logic [SW-1:0]  drx_r  [NDV];
  logic [SW-1:0]  dry_r  [NDV];
  logic [SW-1:0]  dden_r [NDV];
  logic [QW-1:0]  dqx_r  [NDV];
  logic [QW-1:0]  dqy_r  [NDV];
  logic           gex0, gey0;
  logic [OUT_W-1:0] fx, fy;

  // whole pipeline advances unless the last beat cannot leave
  assign adv     = !dv_r[NDV-1] || !out_full;
  assign mid_pop = adv && !mid_empty;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r <= '0;
      mv_r <= 1'b0;
      dv_r <= '0;
    end else if (adv) begin
      sv_r <= {sv_r[NSQ-2:0], mid_pop};
      mv_r <= sv_r[NSQ-1];
      dv_r <= {dv_r[NDV-2:0], mv_r};
    end
  end

  // load from the queue
  always_ff @(posedge clk) begin
    if (adv) begin
      sax_r[0]   <= mid_data[MW-1 -: AW];
      say_r[0]   <= mid_data[MW-1-AW -: AW];
      srem_r[0]  <= mid_data[3 +: SW];
      sroot_r[0] <= '0;
      snx_r[0]   <= mid_data[2];
      sny_r[0]   <= mid_data[1];
      sin_r[0]   <= mid_data[0];
    end
  end

  // one root bit per stage, highest first
  for (genvar k = 0; k < NSQ - 1; k++) begin : g_sq
    localparam logic [SW-1:0] BITV = SW'(1) << (2 * (F - k));
    logic [SW-1:0] trial;
    logic          ge;
    assign trial = sroot_r[k] + BITV;
    assign ge    = (srem_r[k] >= trial);
    always_ff @(posedge clk) begin
      if (adv) begin
        srem_r[k+1]  <= ge ? (srem_r[k] - trial) : srem_r[k];
        sroot_r[k+1] <= ge ? ((sroot_r[k] >> 1) + BITV) : (sroot_r[k] >> 1);
        sax_r[k+1]   <= sax_r[k];
        say_r[k+1]   <= say_r[k];
        snx_r[k+1]   <= snx_r[k];
        sny_r[k+1]   <= sny_r[k];
        sin_r[k+1]   <= sin_r[k];
      end
    end
  end

  // scale numerator and denominator products
  assign len  = sroot_r[NSQ-1][LW-1:0];
  assign mlim = (len < ONE) ? len : ONE;
  assign tnum = mlim - LW'(dz);
  assign omd  = ONE - LW'(dz);

  always_ff @(posedge clk) begin
    if (adv) begin
      mpx_r  <= SW'(sax_r[NSQ-1]) * SW'(tnum);
      mpy_r  <= SW'(say_r[NSQ-1]) * SW'(tnum);
      mden_r <= SW'(omd) * SW'(len);
      mnx_r  <= snx_r[NSQ-1];
      mny_r  <= sny_r[NSQ-1];
      min_r  <= sin_r[NSQ-1];
    end
  end

  // integer quotient bit, which is 0 or 1
  assign gex0 = (mpx_r >= mden_r);
  assign gey0 = (mpy_r >= mden_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      drx_r[0]  <= gex0 ? (mpx_r - mden_r) : mpx_r;
      dry_r[0]  <= gey0 ? (mpy_r - mden_r) : mpy_r;
      dqx_r[0]  <= QW'(gex0);
      dqy_r[0]  <= QW'(gey0);
      dden_r[0] <= mden_r;
      dnx_r[0]  <= mnx_r;
      dny_r[0]  <= mny_r;
      din_r[0]  <= min_r;
    end
  end

  // one fraction bit per stage on both lanes
  for (genvar k = 0; k < NDV - 1; k++) begin : g_dv
    logic [SW:0] shx, shy, dd;
    logic        gex, gey;
    assign shx = {drx_r[k], 1'b0};
    assign shy = {dry_r[k], 1'b0};
    assign dd  = {1'b0, dden_r[k]};
    assign gex = (shx >= dd);
    assign gey = (shy >= dd);
    always_ff @(posedge clk) begin
      if (adv) begin
        drx_r[k+1]  <= SW'(gex ? (shx - dd) : shx);
        dry_r[k+1]  <= SW'(gey ? (shy - dd) : shy);
        dqx_r[k+1]  <= {dqx_r[k][QW-2:0], gex};
        dqy_r[k+1]  <= {dqy_r[k][QW-2:0], gey};
        dden_r[k+1] <= dden_r[k];
        dnx_r[k+1]  <= dnx_r[k];
        dny_r[k+1]  <= dny_r[k];
        din_r[k+1]  <= din_r[k];
      end
    end
  end

  // format the result beat
  assign fx       = to_field(dqx_r[NDV-1], dnx_r[NDV-1]);
  assign fy       = to_field(dqy_r[NDV-1], dny_r[NDV-1]);
  assign out_push = dv_r[NDV-1] && !out_full;
  assign out_data = din_r[NDV-1] ? {{(2*OUT_W){1'b0}}, 1'b1} : {fx, fy, 1'b0};

endmodule

### sv/stick_radial_deadzone_top.sv
// Analog stick conditioning with a scaled radial deadzone.
// Input queue port: a beat of in_raw_x/in_raw_y is taken on a clock edge with in_push
// high and in_full low. Result queue port: while out_empty is low the oldest result sits
// on out_x, out_y and out_in_deadzone; out_pop takes it.
// cfg_we writes cfg_wdata to the deadzone radius (units of 2^-15 of full scale). The user
// must write it only while no beat is in flight; the block does not enforce it.
// Reset sets it to 4915. One beat per cycle is taken and delivered in steady state while
// out_pop is held high. On its way a beat passes the front stages, the middle queue,
// the one-bit-per-stage square root and divider pipelines and the result queue.
// Results come out in push order, one per input beat.
// When out_pop stays low, results gather in a four-deep result queue; once it is full
// the back pipeline holds, then the four-deep middle queue fills, and the front raises
// in_full. Nothing is dropped.
// Reset (rst_n low at a clock edge) empties both queues and all pipeline stages.
module stick_radial_deadzone_top #(
  parameter int FRAC_BITS = 15
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_push,
  output logic                                  in_full,
  input  logic signed [srd_pkg::RAW_W-1:0]      in_raw_x,
  input  logic signed [srd_pkg::RAW_W-1:0]      in_raw_y,
  output logic                                  out_empty,
  input  logic                                  out_pop,
  output logic signed [srd_pkg::OUT_W-1:0]      out_x,
  output logic signed [srd_pkg::OUT_W-1:0]      out_y,
  output logic                                  out_in_deadzone,
  input  logic                                  cfg_we,
  input  logic [srd_pkg::DZ_W-1:0]              cfg_wdata
);
  import srd_pkg::*;

  localparam int F  = FRAC_BITS;
  localparam int MW = 4 * F + 7;
  localparam int OW = 2 * OUT_W + 1;

  logic [DZ_W-1:0]   level_r;
  logic [DZ_W+F-1:0] dz_full;
  logic [F-1:0]      dz;
  logic              mid_push, mid_full, mid_pop, mid_empty;
  logic [MW-1:0]     mid_wdata, mid_rdata;
  logic              res_push, res_full;
  logic [OW-1:0]     res_wdata, res_rdata;

  // deadzone register and its fixed-point radius
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= DZ_RESET;
    end else if (cfg_we) begin
      level_r <= cfg_wdata;
    end
  end

  assign dz_full = {level_r, {F{1'b0}}};
  assign dz      = dz_full[DZ_W+F-1:DZ_W];

  srd_front #(.FRAC_BITS(F)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_raw_x (in_raw_x),
    .in_raw_y (in_raw_y),
    .dz       (dz),
    .mid_full (mid_full),
    .mid_push (mid_push),
    .mid_data (mid_wdata)
  );

  // queue between classification and scaling
  srd_fifo #(.W(MW), .DEPTH(QUEUE_DEPTH)) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mid_push),
    .wdata (mid_wdata),
    .full  (mid_full),
    .pop   (mid_pop),
    .rdata (mid_rdata),
    .empty (mid_empty)
  );

  srd_back #(.FRAC_BITS(F)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .dz        (dz),
    .mid_empty (mid_empty),
    .mid_pop   (mid_pop),
    .mid_data  (mid_rdata),
    .out_full  (res_full),
    .out_push  (res_push),
    .out_data  (res_wdata)
  );

  // result queue toward the receiver
  srd_fifo #(.W(OW), .DEPTH(QUEUE_DEPTH)) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_wdata),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_rdata),
    .empty (out_empty)
  );

  assign out_x           = $signed(res_rdata[OW-1 -: OUT_W]);
  assign out_y           = $signed(res_rdata[1 +: OUT_W]);
  assign out_in_deadzone = res_rdata[0];

endmodule

### sv/srd_checker.sv
// port-level checks for the stick radial deadzone block, bound to the top level
module srd_port_props (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_empty,
  input logic                             out_pop,
  input logic signed [srd_pkg::OUT_W-1:0] out_x,
  input logic signed [srd_pkg::OUT_W-1:0] out_y,
  input logic                             out_in_deadzone
);
  import srd_pkg::*;

  // reset leaves no result waiting
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result present right after reset");

  // a deadzone beat carries zero on both axes
  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_in_deadzone) |-> (out_x == '0 && out_y == '0))
    else $error("deadzone beat with nonzero axis");

  // magnitudes stay within full scale
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_x <= $signed({1'b0, OUT_MAX}) && out_x >= -$signed({1'b0, OUT_MAX})
                    && out_y <= $signed({1'b0, OUT_MAX}) && out_y >= -$signed({1'b0, OUT_MAX})))
    else $error("axis beyond full scale");

  // a waiting result holds until popped
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_x) && $stable(out_y)
                                  && $stable(out_in_deadzone)))
    else $error("waiting result changed");

endmodule

bind stick_radial_deadzone_top srd_port_props u_srd_port_props (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_empty       (out_empty),
  .out_pop         (out_pop),
  .out_x           (out_x),
  .out_y           (out_y),
  .out_in_deadzone (out_in_deadzone)
);

### test/srd_checker.sv
// checker for the stick radial deadzone block: predicts results and compares beats
module srd_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  input  logic                              in_full,
  input  logic signed [srd_pkg::RAW_W-1:0]  in_raw_x,
  input  logic signed [srd_pkg::RAW_W-1:0]  in_raw_y,
  input  logic                              out_empty,
  input  logic                              out_pop,
  input  logic signed [srd_pkg::OUT_W-1:0]  out_x,
  input  logic signed [srd_pkg::OUT_W-1:0]  out_y,
  input  logic                              out_in_deadzone,
  input  logic                              cfg_we,
  input  logic [srd_pkg::DZ_W-1:0]          cfg_wdata,
  output int                                fail_count,
  output int                                pending
);
  import srd_pkg::*;

  localparam int FB = 15;
  localparam logic [63:0] ONE_Q = 64'd1 << FB;

  typedef struct packed {
    logic [OUT_W-1:0] x;
    logic [OUT_W-1:0] y;
    logic             dz;
  } stick_res_t;

  stick_res_t       expected_q[$];
  logic [DZ_W-1:0]  radius_reg;

  assign pending = expected_q.size();

  function automatic logic [63:0] floor_root(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // axis magnitude in fixed point, sign returned separately
  function automatic logic [63:0] axis_mag(logic [RAW_W-1:0] raw, output logic neg);
    logic [63:0] v;
    v = {48'd0, raw};
    neg = raw[RAW_W-1];
    if (neg) return ((64'd65536 - v) * ONE_Q) >> 15;
    return (v * ONE_Q) / 64'd32767;
  endfunction

  function automatic logic [OUT_W-1:0] signed_field(logic [63:0] mag, logic neg);
    logic [63:0] m;
    m = (mag * 64'd32768) >> FB;
    if (m > 64'd32768) m = 64'd32768;
    if (neg) return OUT_W'(64'h20000 - m);
    return OUT_W'(m);
  endfunction

  function automatic stick_res_t condition_stick(logic [RAW_W-1:0] rx, logic [RAW_W-1:0] ry,
                                                 logic [DZ_W-1:0] level);
    stick_res_t  r;
    logic        nx, ny;
    logic [63:0] ax, ay, dzq, sum, len, m, den;
    ax  = axis_mag(rx, nx);
    ay  = axis_mag(ry, ny);
    ny  = !ny;
    dzq = ({49'd0, level} * ONE_Q) >> 15;
    sum = ax * ax + ay * ay;
    if (sum <= dzq * dzq) begin
      r.x = '0;
      r.y = '0;
      r.dz = 1'b1;
      return r;
    end
    len = floor_root(sum);
    m   = (len < ONE_Q) ? len : ONE_Q;
    den = (ONE_Q - dzq) * len;
    r.x  = signed_field(((ax * (m - dzq)) << FB) / den, nx);
    r.y  = signed_field(((ay * (m - dzq)) << FB) / den, ny);
    r.dz = 1'b0;
    return r;
  endfunction

  // track the register, predict accepted beats, compare delivered ones
  always @(posedge clk) begin
    stick_res_t e;
    int         errs;
    errs = 0;
    if (!rst_n) begin
      radius_reg <= DZ_RESET;
      expected_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) radius_reg <= cfg_wdata;
      if (in_push && !in_full)
        expected_q.push_back(condition_stick(in_raw_x, in_raw_y, radius_reg));
      if (out_pop && !out_empty) begin
        if (expected_q.size() == 0) begin
          $error("result beat with nothing expected");
          errs = errs + 1;
        end else begin
          e = expected_q.pop_front();
          if (out_x !== e.x) begin
            $error("out_x expected %0d got %0d", $signed(e.x), out_x);
            errs = errs + 1;
          end
          if (out_y !== e.y) begin
            $error("out_y expected %0d got %0d", $signed(e.y), out_y);
            errs = errs + 1;
          end
          if (out_in_deadzone !== e.dz) begin
            $error("in_deadzone expected %0d got %0d", e.dz, out_in_deadzone);
            errs = errs + 1;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
  end
endmodule

### test/tb_top.sv
// stimulus and verdict for the stick radial deadzone block
module tb_top;
  import srd_pkg::*;

  localparam int WATCH_LIMIT = 20000;

  logic              clk;
  logic              rst_n;
  logic              in_push;
  logic              in_full;
  logic [RAW_W-1:0]  in_raw_x;
  logic [RAW_W-1:0]  in_raw_y;
  logic              out_empty;
  logic              out_pop;
  logic [OUT_W-1:0]  out_x;
  logic [OUT_W-1:0]  out_y;
  logic              out_in_deadzone;
  logic              cfg_we;
  logic [DZ_W-1:0]   cfg_wdata;
  int                fail_count;
  int                pending;
  int                idle_cycles;
  int                send_idle_pct;
  int                pop_stall_pct;

  stick_radial_deadzone_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_raw_x(in_raw_x), .in_raw_y(in_raw_y),
    .out_empty(out_empty), .out_pop(out_pop), .out_x(out_x), .out_y(out_y),
    .out_in_deadzone(out_in_deadzone), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  srd_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_raw_x(in_raw_x), .in_raw_y(in_raw_y),
    .out_empty(out_empty), .out_pop(out_pop), .out_x(out_x), .out_y(out_y),
    .out_in_deadzone(out_in_deadzone), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // receiver side with random stalls
  always @(posedge clk) begin
    out_pop <= ($urandom_range(99) >= pop_stall_pct);
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCH_LIMIT) begin
        $display("tb_top failed");
        $finish;
      end
    end
  end

  // push one beat, idling first at the current rate
  task automatic send_stick(logic [RAW_W-1:0] x, logic [RAW_W-1:0] y);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push  <= 1'b1;
    in_raw_x <= x;
    in_raw_y <= y;
    @(posedge clk);
    while (in_full) @(posedge clk);
  endtask

  task automatic drain_and_set(logic [DZ_W-1:0] level);
    in_push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= level;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [RAW_W-1:0] pick_axis();
    case ($urandom_range(5))
      0: return RAW_W'($urandom_range(8) + 16'h7FF8);
      1: return RAW_W'(16'h8000 + $urandom_range(8));
      2: return RAW_W'($urandom_range(2000) - 1000);
      default: return RAW_W'($urandom);
    endcase
  endfunction

  initial begin
    logic [DZ_W-1:0] levels[6];
    logic [RAW_W-1:0] edge_vals[6];
    int pct_set[4][2];
    levels = '{15'd0, 15'h7FFF, 15'd4915, 15'd16384, 15'd1, 15'd32000};
    edge_vals = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001, 16'h5555};
    pct_set = '{'{0, 0}, '{67, 0}, '{0, 67}, '{33, 33}};
    rst_n = 1'b0;
    in_push = 1'b0;
    in_raw_x = '0;
    in_raw_y = '0;
    out_pop = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    send_idle_pct = 0;
    pop_stall_pct = 0;
    idle_cycles = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed beats, first at reset radius: corners, axes, zero, deadzone edge
    foreach (edge_vals[i]) send_stick(edge_vals[i], edge_vals[(i + 2) % 6]);
    send_stick(16'sd4915, 16'sd0);
    send_stick(16'sd4916, 16'sd0);
    send_stick(16'sd0, -16'sd4915);
    send_stick(16'sd3475, 16'sd3475);
    send_stick(16'h8000, 16'h8000);
    send_stick(16'h7FFF, 16'h7FFF);
    drain_and_set(15'h7FFF);
    send_stick(16'h8000, 16'h8000);
    send_stick(16'h7FFF, 16'h0000);
    drain_and_set(15'd0);
    send_stick(16'h0000, 16'h0000);
    send_stick(16'h0001, 16'hFFFF);
    send_stick(16'h8000, 16'h7FFF);

    // random beats over radius settings and idle phases
    for (int p = 0; p < 12; p++) begin
      drain_and_set(levels[p % 6] ^ ((p >= 6) ? DZ_W'($urandom_range(255)) : '0));
      send_idle_pct = pct_set[p % 4][0];
      pop_stall_pct = pct_set[p % 4][1];
      for (int n = 0; n < 145; n++) send_stick(pick_axis(), pick_axis());
    end
    in_push <= 1'b0;
    send_idle_pct = 0;
    pop_stall_pct = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end
endmodule

### stick_radial_deadzone_top.f
sv/srd_pkg.sv
sv/srd_fifo.sv
sv/srd_front.sv
sv/srd_back.sv
sv/stick_radial_deadzone_top.sv
sv/srd_checker.sv
test/srd_checker.sv
test/tb_top.sv
